// File: sv/flc_pkg.sv
// Shared types and constants for the full linear convolution block.
`timescale 1ns / 1ps
`default_nettype none

package flc_pkg;

  localparam int DEF_TAPS  = 8;
  localparam int NUM_COEFF = 8;
  localparam int CFG_IDX_W = $clog2(NUM_COEFF);
  localparam int SAMPLE_W  = 16;
  localparam int COEFF_W   = 16;
  localparam int PROD_W    = SAMPLE_W + COEFF_W;
  localparam int CONV_W    = PROD_W + $clog2(NUM_COEFF);
  localparam int QDEPTH    = 6;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEFF_W-1:0]  coeff_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [CONV_W-1:0] conv_value;
    logic                     run_end;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic run_end;
  } ctl_t;

endpackage

`default_nettype wire

// File: sv/flc_cell.sv
// One tap cell: holds a delayed sample and the registered tap product.
`timescale 1ns / 1ps
`default_nettype none

module flc_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  flc_pkg::coeff_t  coeff,
  input  flc_pkg::sample_t din,
  output flc_pkg::sample_t tap,
  output flc_pkg::prod_t   prod
);
  import flc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else if (shift) begin
      tap <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      prod <= coeff * din;
    end
  end

endmodule

`default_nettype wire

// File: sv/flc_sum_tree.sv
// Three-level registered adder tree over the tap products.
`timescale 1ns / 1ps
`default_nettype none

module flc_sum_tree (
  input  logic                                clk,
  input  logic                                rst,
  input  flc_pkg::ctl_t                       ctl_in,
  input  flc_pkg::prod_t [flc_pkg::NUM_COEFF-1:0] prod,
  output flc_pkg::ctl_t                       ctl_out,
  output flc_pkg::out_item_t                  item
);
  import flc_pkg::*;

  localparam int L1_W = PROD_W + 1;
  localparam int L2_W = PROD_W + 2;

  logic signed [L1_W-1:0] s1 [4];
  logic signed [L2_W-1:0] s2 [2];
  ctl_t ctl1;
  ctl_t ctl2;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      ctl_out <= '0;
    end else begin
      ctl1    <= ctl_in;
      ctl2    <= ctl1;
      ctl_out <= ctl2;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      s1[i] <= L1_W'($signed(prod[2*i])) + L1_W'($signed(prod[2*i+1]));
    end
    for (int j = 0; j < 2; j++) begin
      s2[j] <= L2_W'(s1[2*j]) + L2_W'(s1[2*j+1]);
    end
    item.conv_value <= CONV_W'(s2[0]) + CONV_W'(s2[1]);
    item.run_end    <= ctl2.run_end;
  end

endmodule

`default_nettype wire

// File: sv/flc_out_queue.sv
// Small result queue that decouples the sum pipeline from the output stall.
`timescale 1ns / 1ps
`default_nettype none

module flc_out_queue #(
  parameter int DEPTH = flc_pkg::QDEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  flc_pkg::out_item_t wr_item,
  input  logic               rd,
  output logic               not_empty,
  output flc_pkg::out_item_t rd_item
);
  import flc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= bump(wr_ptr);
      if (rd) rd_ptr <= bump(rd_ptr);
      count <= count + CNT_W'(wr) - CNT_W'(rd);
    end
  end

  assign not_empty = (count != '0);
  assign rd_item   = mem[rd_ptr];

endmodule

`default_nettype wire

// File: sv/full_linear_convolution.sv
// Top level of the block-wise full linear convolution filter.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one sample per clock while sample_stall is low and returns one exact 35-bit
// sum per sample. A sample marked block_end is followed by TAPS-1 tail results
// computed with zeros shifted in; the input stalls until all of them are issued,
// after which the taps feeding the products are all zero. An accepted sample reaches
// the output through the tap cell products, taken at the accepting edge, then a
// three-level adder tree and the result queue. The queue holds six items, so a stalled
// output stops input only once six items are outstanding. Coefficients must be
// written on the cfg port only while no item is in flight; this is not enforced.

module full_linear_convolution #(
  parameter int TAPS = flc_pkg::DEF_TAPS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  flc_pkg::in_item_t               sample_data,
  output logic                            result_valid,
  input  logic                            result_stall,
  output flc_pkg::out_item_t              result_data,
  input  logic                            cfg_we,
  input  logic [flc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [flc_pkg::COEFF_W-1:0]     cfg_data
);
  import flc_pkg::*;

  localparam int TW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int PND_W = $clog2(QDEPTH + 1);

  coeff_t                  coeff [NUM_COEFF];
  logic [TW-1:0]           tail_left;
  logic [PND_W-1:0]        pending;
  logic                    flushing;
  logic                    space;
  logic                    push_in;
  logic                    push_tail;
  logic                    push;
  logic                    pop;
  sample_t                 x;
  logic                    last;
  sample_t                 taps [TAPS];
  prod_t [NUM_COEFF-1:0]   prod;
  ctl_t                    prod_ctl;
  ctl_t                    sum_ctl;
  out_item_t               sum_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFF; i++) coeff[i] <= '0;
    end else if (cfg_we) begin
      coeff[cfg_index] <= coeff_t'(cfg_data);
    end
  end

  assign flushing     = (tail_left != '0);
  assign space        = (pending < PND_W'(QDEPTH));
  assign sample_stall = flushing || !space;
  assign push_in      = sample_valid && !sample_stall;
  assign push_tail    = flushing && space;
  assign push         = push_in || push_tail;
  assign pop          = result_valid && !result_stall;

  always_comb begin
    if (push_tail) begin
      x    = '0;
      last = (tail_left == TW'(1));
    end else begin
      x    = sample_data.sample;
      last = sample_data.block_end && (TAPS == 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_left <= '0;
      pending   <= '0;
      prod_ctl  <= '0;
    end else begin
      if (push_in && sample_data.block_end) begin
        tail_left <= TW'(TAPS - 1);
      end else if (push_tail) begin
        tail_left <= tail_left - TW'(1);
      end
      pending  <= pending + PND_W'(push) - PND_W'(pop);
      prod_ctl <= '{valid: push, run_end: last};
    end
  end

  for (genvar k = 0; k < NUM_COEFF; k++) begin : g_cell
    if (k < TAPS) begin : g_used
      flc_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (push),
        .coeff (coeff[k]),
        .din   ((k == 0) ? x : taps[(k > 0) ? k - 1 : 0]),
        .tap   (taps[k]),
        .prod  (prod[k])
      );
    end else begin : g_pad
      assign prod[k] = '0;
    end
  end

  flc_sum_tree u_tree (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (prod_ctl),
    .prod    (prod),
    .ctl_out (sum_ctl),
    .item    (sum_item)
  );

  flc_out_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (sum_ctl.valid),
    .wr_item   (sum_item),
    .rd        (pop),
    .not_empty (result_valid),
    .rd_item   (result_data)
  );

endmodule

`default_nettype wire

// File: sv/flc_checker.sv
// Port-level checks for the full linear convolution block and their binding.
`timescale 1ns / 1ps
`default_nettype none

module flc_checker #(
  parameter int TAPS = flc_pkg::DEF_TAPS
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_stall,
  input flc_pkg::in_item_t             sample_data,
  input logic                          result_valid,
  input logic                          result_stall,
  input flc_pkg::out_item_t            result_data,
  input logic                          cfg_we,
  input logic [flc_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [flc_pkg::COEFF_W-1:0]   cfg_data
);
  import flc_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("stalled result item changed or dropped");

  a_tail_stall: assert property (@(posedge clk) disable iff (rst)
    (TAPS > 1) && sample_valid && !sample_stall && sample_data.block_end |=> sample_stall)
    else $error("input not stalled during tail flush");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result item present after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> !sample_stall)
    else $error("input stalled after reset");

endmodule

bind full_linear_convolution flc_checker #(.TAPS(TAPS)) u_flc_checker (.*);

`default_nettype wire
